// File: rtl/sigmoid_product_membership_defines.svh
// Assertion macros used by the checker file of this block.
`ifndef SIGMOID_PRODUCT_MEMBERSHIP_DEFINES_SVH
`define SIGMOID_PRODUCT_MEMBERSHIP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPM_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPM_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/spm_pkg.sv
package spm_pkg;

    // Fixed-point payload types.
    typedef logic signed [15:0] spm_q8_8_t;
    typedef logic [15:0]        spm_q1_15_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_LEFT_POINT    = 3'd0,
        REG_RISING_SLOPE  = 3'd1,
        REG_FALLING_SLOPE = 3'd2,
        REG_RIGHT_POINT   = 3'd3,
        REG_PEAK_HEIGHT   = 3'd4
    } spm_reg_t;

    localparam int CFG_INDEX_W = 3;

    // Register reset values.
    localparam spm_q8_8_t  LEFT_POINT_RESET    = 16'sd0;
    localparam spm_q8_8_t  RISING_SLOPE_RESET  = 16'sd256;
    localparam spm_q8_8_t  FALLING_SLOPE_RESET = -16'sd256;
    localparam spm_q8_8_t  RIGHT_POINT_RESET   = 16'sd0;
    localparam spm_q1_15_t PEAK_HEIGHT_RESET   = 16'd32768;

    // Pipeline depth: five stages per sigmoid unit, two in the combiner.
    localparam int SIG_STAGES = 5;
    localparam int MIX_STAGES = 2;
    localparam int STAGES     = SIG_STAGES + MIX_STAGES;

    // Stage load enables handed to the datapath units.
    typedef struct packed {
        logic [SIG_STAGES-1:0] load;
    } spm_sig_ctrl_t;

    typedef struct packed {
        logic [MIX_STAGES-1:0] load;
    } spm_mix_ctrl_t;

    // Shift-subtract long division, used only while building the table.
    function automatic logic [63:0] spm_long_div(input logic [63:0] num,
                                                 input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        int          b;
        rem = '0;
        quo = '0;
        for (b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // exp(x) for x in [0, 1], Q2.30, by a 21-term Taylor series.
    function automatic logic [63:0] spm_exp_q30(input logic [63:0] x);
        logic [63:0] term;
        logic [63:0] sum;
        int          k;
        term = 64'd1 << 30;
        sum  = 64'd1 << 30;
        for (k = 1; k <= 20; k++) begin
            term = spm_long_div((term * x) >> 30, 64'(k));
            sum  = sum + term;
        end
        return sum;
    endfunction

    // Logistic table entry at grid point -16 + 32*i/n, Q1.15.
    function automatic logic [15:0] spm_logistic_entry(input int i, input int n);
        int          m;
        logic [63:0] mag;
        logic [63:0] a;
        logic [63:0] whole;
        logic [63:0] f;
        logic [63:0] inv_e;
        logic [63:0] q;
        logic [63:0] den;
        logic [63:0] t;
        int          j;
        m     = 2 * i - n;
        mag   = (m < 0) ? 64'(-m) : 64'(m);
        a     = spm_long_div(mag << 34, 64'(n));
        whole = a >> 30;
        f     = a & ((64'd1 << 30) - 64'd1);
        inv_e = spm_long_div(64'd1 << 60, spm_exp_q30(64'd1 << 30));
        q     = spm_long_div(64'd1 << 60, spm_exp_q30(f));
        for (j = 0; j < 64; j++) begin
            if (64'(j) < whole) begin
                q = (q * inv_e) >> 30;
            end
        end
        den = (64'd1 << 30) + q;
        t   = spm_long_div((64'd1 << 45) + (den >> 1), den);
        if (m < 0) begin
            t = 64'd32768 - t;
        end
        return t[15:0];
    endfunction

endpackage

// File: rtl/spm_sample_if.sv
interface spm_sample_if;
    import spm_pkg::*;

    logic      valid;
    logic      ready;
    spm_q8_8_t sample;
    logic      sample_undefined;

    modport source (output valid, output sample, output sample_undefined, input ready);
    modport sink   (input valid, input sample, input sample_undefined, output ready);
endinterface

// File: rtl/spm_degree_if.sv
interface spm_degree_if;
    import spm_pkg::*;

    logic       valid;
    logic       ready;
    spm_q1_15_t degree;
    logic       degree_undefined;

    modport source (output valid, output degree, output degree_undefined, input ready);
    modport sink   (input valid, input degree, input degree_undefined, output ready);
endinterface

// File: rtl/spm_cfg_if.sv
interface spm_cfg_if;
    import spm_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [15:0]            data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/spm_sigmoid.sv
module spm_sigmoid #(
    parameter int LOGISTIC_TABLE_ENTRIES = 256
) (
    input  logic                   clk,
    input  spm_pkg::spm_sig_ctrl_t ctrl,
    input  spm_pkg::spm_q8_8_t     sample,
    input  spm_pkg::spm_q8_8_t     slope,
    input  spm_pkg::spm_q8_8_t     point,
    output spm_pkg::spm_q1_15_t    value
);
    import spm_pkg::*;

    localparam int N     = LOGISTIC_TABLE_ENTRIES;
    localparam int IDX_W = $clog2(N + 1);
    localparam int P_W   = 21 + IDX_W;

    // Logistic table, evaluated at elaboration.
    logic [15:0] logistic_rom [0:N];

    for (genvar gi = 0; gi <= N; gi++) begin : g_rom
        localparam logic [15:0] ENTRY = spm_logistic_entry(gi, N);
        assign logistic_rom[gi] = ENTRY;
    end

    logic signed [16:0] diff_reg, diff_next;
    logic signed [32:0] arg_reg, arg_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [20:0]        frac_reg, frac_next;
    logic [20:0]        frac4_reg;
    logic [15:0]        base_reg, base_next;
    logic [15:0]        step_reg, step_next;
    logic [15:0]        value_reg, value_next;

    logic signed [21:0] arg_sat;
    logic [21:0]        arg_offset;
    logic [P_W-1:0]     pos;
    logic [IDX_W-1:0]   idx_hi;
    logic [15:0]        lo, hi;
    logic [37:0]        interp;

    // Stage 1: distance of the sample from the inflection point.
    assign diff_next = {sample[15], sample} - {point[15], point};

    // Stage 2: scale by the slope, Q16.16.
    assign arg_next = $signed({{17{slope[15]}}, slope}) * $signed({{16{diff_reg[16]}}, diff_reg});

    // Stage 3: saturate to +-16 and split into table index and fraction.
    always_comb
    begin
        if (arg_reg > 33'sd1048576) begin
            arg_sat = 22'sd1048576;
        end else if (arg_reg < -33'sd1048576) begin
            arg_sat = -22'sd1048576;
        end else begin
            arg_sat = arg_reg[21:0];
        end
        arg_offset = 22'(arg_sat) + 22'd1048576;
        pos        = P_W'(arg_offset) * P_W'(N);
        idx_next   = pos[P_W-1:21];
        frac_next  = pos[20:0];
    end

    // Stage 4: table lookup of the two neighbors; the last entry stands alone.
    always_comb
    begin
        idx_hi = (idx_reg == IDX_W'(N)) ? idx_reg : idx_reg + IDX_W'(1);
        lo     = logistic_rom[idx_reg];
        hi     = logistic_rom[idx_hi];
        if (idx_reg == IDX_W'(N)) begin
            base_next = logistic_rom[N];
            step_next = '0;
        end else begin
            base_next = lo;
            step_next = (hi < lo) ? 16'd0 : hi - lo;
        end
    end

    // Stage 5: linear interpolation with rounding.
    always_comb
    begin
        interp     = 38'(step_reg) * 38'(frac4_reg) + 38'd1048576;
        value_next = base_reg + interp[36:21];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0]) begin
            diff_reg <= diff_next;
        end
        if (ctrl.load[1]) begin
            arg_reg <= arg_next;
        end
        if (ctrl.load[2]) begin
            idx_reg  <= idx_next;
            frac_reg <= frac_next;
        end
        if (ctrl.load[3]) begin
            base_reg  <= base_next;
            step_reg  <= step_next;
            frac4_reg <= frac_reg;
        end
        if (ctrl.load[4]) begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

// File: rtl/spm_combine.sv
module spm_combine (
    input  logic                   clk,
    input  spm_pkg::spm_mix_ctrl_t ctrl,
    input  spm_pkg::spm_q1_15_t    rise,
    input  spm_pkg::spm_q1_15_t    fall,
    input  spm_pkg::spm_q1_15_t    height,
    input  logic                   undefined,
    output spm_pkg::spm_q1_15_t    degree,
    output logic                   degree_undefined
);
    import spm_pkg::*;

    logic [30:0] prod_reg, prod_next;
    logic        undef_reg;
    logic [15:0] degree_reg, degree_next;
    logic        degree_undef_reg;
    logic [46:0] scaled;

    // Stage 6: product of the two sigmoids, Q2.30.
    assign prod_next = 31'(32'(rise) * 32'(fall));

    // Stage 7: scale by the height and round back to Q1.15; an undefined sample gives zero.
    always_comb
    begin
        scaled      = 47'(prod_reg) * 47'(height) + 47'd536870912;
        degree_next = undef_reg ? 16'd0 : scaled[45:30];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0]) begin
            prod_reg  <= prod_next;
            undef_reg <= undefined;
        end
        if (ctrl.load[1]) begin
            degree_reg       <= degree_next;
            degree_undef_reg <= undef_reg;
        end
    end

    assign degree           = degree_reg;
    assign degree_undefined = degree_undef_reg;

endmodule

// File: rtl/sigmoid_product_membership.sv
// Throughput: one sample per cycle while the output is taken; each of the 7 stages
// loads whenever it is empty or the stage after it moves, so bubbles close up
// behind a stalled output.
// Reset: rst_n clears all stage valid bits and sets the configuration registers to
// their defaults; the logistic table is a constant and needs no fill.
module sigmoid_product_membership #(
    parameter int LOGISTIC_TABLE_ENTRIES = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    spm_sample_if.sink     samples,
    spm_degree_if.source   degrees,
    spm_cfg_if.sink        cfg
);
    import spm_pkg::*;

    spm_q8_8_t  left_point_reg;
    spm_q8_8_t  rising_slope_reg;
    spm_q8_8_t  falling_slope_reg;
    spm_q8_8_t  right_point_reg;
    spm_q1_15_t peak_height_reg;

    logic [STAGES-1:0]     valid_reg;
    logic [SIG_STAGES-1:0] undef_reg;
    logic [STAGES-1:0]     load;

    spm_sig_ctrl_t sig_ctrl;
    spm_mix_ctrl_t mix_ctrl;
    spm_q1_15_t    rise_value;
    spm_q1_15_t    fall_value;

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            left_point_reg    <= LEFT_POINT_RESET;
            rising_slope_reg  <= RISING_SLOPE_RESET;
            falling_slope_reg <= FALLING_SLOPE_RESET;
            right_point_reg   <= RIGHT_POINT_RESET;
            peak_height_reg   <= PEAK_HEIGHT_RESET;
        end else if (cfg.valid) begin
            unique case (cfg.index)
                REG_LEFT_POINT:    left_point_reg    <= cfg.data;
                REG_RISING_SLOPE:  rising_slope_reg  <= cfg.data;
                REG_FALLING_SLOPE: falling_slope_reg <= cfg.data;
                REG_RIGHT_POINT:   right_point_reg   <= cfg.data;
                REG_PEAK_HEIGHT:   peak_height_reg   <= cfg.data;
                default:           ;
            endcase
        end
    end

    // A stage loads when it is empty or its contents move on.
    always_comb
    begin
        load[STAGES-1] = !valid_reg[STAGES-1] || degrees.ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    assign samples.ready = load[0];
    assign sig_ctrl.load = load[SIG_STAGES-1:0];
    assign mix_ctrl.load = load[STAGES-1:SIG_STAGES];

    // Valid bits and the undefined flag travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
        end else begin
            if (load[0]) begin
                valid_reg[0] <= samples.valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (load[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0]) begin
            undef_reg[0] <= samples.sample_undefined;
        end
        for (int k = 1; k < SIG_STAGES; k++) begin
            if (load[k]) begin
                undef_reg[k] <= undef_reg[k-1];
            end
        end
    end

    // Rising sigmoid.
    spm_sigmoid #(
        .LOGISTIC_TABLE_ENTRIES (LOGISTIC_TABLE_ENTRIES)
    ) u_rise (
        .clk    (clk),
        .ctrl   (sig_ctrl),
        .sample (samples.sample),
        .slope  (rising_slope_reg),
        .point  (left_point_reg),
        .value  (rise_value)
    );

    // Falling sigmoid.
    spm_sigmoid #(
        .LOGISTIC_TABLE_ENTRIES (LOGISTIC_TABLE_ENTRIES)
    ) u_fall (
        .clk    (clk),
        .ctrl   (sig_ctrl),
        .sample (samples.sample),
        .slope  (falling_slope_reg),
        .point  (right_point_reg),
        .value  (fall_value)
    );

    // Product, height scaling and output register.
    spm_combine u_combine (
        .clk              (clk),
        .ctrl             (mix_ctrl),
        .rise             (rise_value),
        .fall             (fall_value),
        .height           (peak_height_reg),
        .undefined        (undef_reg[SIG_STAGES-1]),
        .degree           (degrees.degree),
        .degree_undefined (degrees.degree_undefined)
    );

    assign degrees.valid = valid_reg[STAGES-1];

endmodule

// File: rtl/spm_checker.sv
`include "sigmoid_product_membership_defines.svh"

module spm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] degree,
    input logic        degree_undefined,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    // A stalled result holds its value.
    `SPM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(degree) && $stable(degree_undefined), "stalled result changed")

    // An undefined sample always gives a zero degree.
    `SPM_ASSERT_NOW(a_undef_zero, clk, rst_n, out_valid && degree_undefined, degree == 16'd0, "undefined result with nonzero degree")

    // A ready output side never blocks the input side.
    `SPM_ASSERT_NOW(a_ready_flow, clk, rst_n, out_ready, in_ready, "input stalled while output is ready")

    // Configuration writes are never back-pressured.
    `SPM_ASSERT_NOW(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready, "configuration write stalled")

endmodule

bind sigmoid_product_membership spm_checker u_spm_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_ready         (samples.ready),
    .out_valid        (degrees.valid),
    .out_ready        (degrees.ready),
    .degree           (degrees.degree),
    .degree_undefined (degrees.degree_undefined),
    .cfg_valid        (cfg.valid),
    .cfg_ready        (cfg.ready)
);

// File: bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import spm_pkg::*;

    typedef logic [63:0] u64_t;

    // One expected degree transaction.
    typedef struct {
        spm_q1_15_t degree;
        logic       undefined;
    } degree_item_t;

    localparam int     TABLE_ENTRIES   = 256;
    localparam int     IDLE_PERCENT    = 33;
    localparam int     HOLD_OFF_CYCLES = 120;
    localparam int     DRAIN_CYCLES    = 2 * STAGES + 4;
    localparam int     RANDOM_PHASES   = 8;
    localparam int     PHASE_ITEMS     = 66;
    localparam int     STEADY_PHASE    = 3;
    localparam int     STALL_ITEMS     = 30;
    localparam longint ARG_LIMIT       = 1048576;
    localparam u64_t   ONE_Q30         = 64'd1 << 30;
    localparam u64_t   ONE_Q15         = 64'd32768;

    localparam logic [CFG_INDEX_W-1:0] FIRST_UNMAPPED_INDEX = 3'd5;

    logic clk;
    logic rst_n;

    spm_sample_if sample_bus ();
    spm_degree_if degree_bus ();
    spm_cfg_if    cfg_bus ();

    sigmoid_product_membership #(
        .LOGISTIC_TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_bus),
        .degrees (degree_bus),
        .cfg     (cfg_bus)
    );

    // Shadow copy of the configuration registers and the logistic table.
    spm_q8_8_t    left_point_r;
    spm_q8_8_t    rising_slope_r;
    spm_q8_8_t    falling_slope_r;
    spm_q8_8_t    right_point_r;
    spm_q1_15_t   peak_height_r;
    logic [15:0]  logistic_lut [0:TABLE_ENTRIES];

    degree_item_t pending_degrees [$];
    int           error_count;

    // Shared controls: steady_flow turns off idling on both sides, and a toggle of
    // hold_toggle asks the receiver for one long hold-off.
    logic         steady_flow;
    logic         hold_toggle;
    logic         hold_seen;
    int           hold_left;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // exp(x) for x in [0, 1] in Q2.30 by a truncated Taylor series.
    function automatic u64_t exp_taylor_q30(input u64_t x);
        u64_t term;
        u64_t sum;
        term = ONE_Q30;
        sum  = ONE_Q30;
        for (int k = 1; k <= 20; k++)
        begin
            term = ((term * x) >> 30) / u64_t'(k);
            sum  = sum + term;
        end
        return sum;
    endfunction

    // Logistic value in Q1.15 at grid point -16 + 32*i/N.
    function automatic logic [15:0] logistic_entry(input int i);
        int   m;
        u64_t mag;
        u64_t arg;
        u64_t whole;
        u64_t frac;
        u64_t inv_e;
        u64_t q;
        u64_t den;
        u64_t t;
        m     = 2 * i - TABLE_ENTRIES;
        mag   = u64_t'((m < 0) ? -m : m);
        arg   = (mag << 34) / u64_t'(TABLE_ENTRIES);
        whole = arg >> 30;
        frac  = arg & (ONE_Q30 - 64'd1);
        inv_e = (ONE_Q30 * ONE_Q30) / exp_taylor_q30(ONE_Q30);
        q     = (ONE_Q30 * ONE_Q30) / exp_taylor_q30(frac);
        while (whole != 0)
        begin
            q     = (q * inv_e) >> 30;
            whole = whole - 64'd1;
        end
        den = ONE_Q30 + q;
        t   = ((u64_t'(1) << 45) + den / 2) / den;
        if (m < 0)
        begin
            t = ONE_Q15 - t;
        end
        return t[15:0];
    endfunction

    // One sigmoid with a saturated argument and linear table interpolation.
    function automatic u64_t sigmoid_q15(input spm_q8_8_t slope, input spm_q8_8_t point,
                                         input spm_q8_8_t x);
        longint z;
        u64_t   p;
        u64_t   idx;
        u64_t   r;
        u64_t   lo;
        u64_t   hi;
        z = longint'(slope) * (longint'(x) - longint'(point));
        if (z > ARG_LIMIT)
        begin
            z = ARG_LIMIT;
        end
        else if (z < -ARG_LIMIT)
        begin
            z = -ARG_LIMIT;
        end
        p   = u64_t'(z + ARG_LIMIT) * u64_t'(TABLE_ENTRIES);
        idx = p >> 21;
        r   = p & ((u64_t'(1) << 21) - 64'd1);
        if (idx >= u64_t'(TABLE_ENTRIES))
        begin
            return u64_t'(logistic_lut[TABLE_ENTRIES]);
        end
        lo = u64_t'(logistic_lut[idx]);
        hi = u64_t'(logistic_lut[idx + 1]);
        if (hi < lo)
        begin
            hi = lo;
        end
        return lo + (((hi - lo) * r + (u64_t'(1) << 20)) >> 21);
    endfunction

    // Expected degree transaction for one sample under the current settings.
    function automatic degree_item_t predict_degree(input spm_q8_8_t value,
                                                    input logic undefined_flag);
        degree_item_t item;
        u64_t         product;
        item.degree    = '0;
        item.undefined = undefined_flag;
        if (!undefined_flag)
        begin
            product = sigmoid_q15(rising_slope_r, left_point_r, value)
                    * sigmoid_q15(falling_slope_r, right_point_r, value)
                    * u64_t'(peak_height_r);
            product     = (product + (u64_t'(1) << 29)) >> 30;
            item.degree = product[15:0];
        end
        return item;
    endfunction

    // Random picks for settings and samples, with the extremes favored.
    function automatic spm_q8_8_t pick_slope();
        case ($urandom_range(9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            3, 4, 5: return spm_q8_8_t'($urandom_range(1024) - 512);
            default: return spm_q8_8_t'($urandom);
        endcase
    endfunction

    function automatic spm_q8_8_t pick_point();
        case ($urandom_range(9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return spm_q8_8_t'($urandom_range(2048) - 1024);
            default: return spm_q8_8_t'($urandom);
        endcase
    endfunction

    function automatic spm_q1_15_t pick_height();
        case ($urandom_range(9))
            0:       return 16'd0;
            1:       return 16'd32768;
            2:       return spm_q1_15_t'($urandom);
            default: return spm_q1_15_t'($urandom_range(32768));
        endcase
    endfunction

    // Samples cluster around the inflection points so both slopes get exercised.
    function automatic spm_q8_8_t pick_sample();
        case ($urandom_range(7))
            0, 1, 2: return spm_q8_8_t'(left_point_r + $urandom_range(4095) - 2048);
            3, 4:    return spm_q8_8_t'(right_point_r + $urandom_range(4095) - 2048);
            5:       return $urandom_range(1) ? 16'sh8000 : 16'sh7FFF;
            default: return spm_q8_8_t'($urandom);
        endcase
    endfunction

    // Offer one sample transaction and record its expected degree once accepted.
    // Valid stays high afterwards so back-to-back transactions need no new edge.
    task automatic send_sample(input spm_q8_8_t value, input logic undefined_flag);
        if (!steady_flow && $urandom_range(99) < IDLE_PERCENT)
        begin
            sample_bus.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < IDLE_PERCENT);
        end
        sample_bus.valid            <= 1'b1;
        sample_bus.sample           <= value;
        sample_bus.sample_undefined <= undefined_flag;
        do @(posedge clk); while (!sample_bus.ready);
        pending_degrees.push_back(predict_degree(value, undefined_flag));
    endtask

    // Stop offering samples and wait until every expected degree has arrived.
    task automatic wait_for_degrees();
        sample_bus.valid <= 1'b0;
        while (pending_degrees.size() != 0) @(posedge clk);
    endtask

    // One register write transaction; the caller lowers valid when done.
    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] reg_index,
                             input logic [15:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= reg_index;
        cfg_bus.data  <= value;
        do @(posedge clk); while (!cfg_bus.ready);
        case (reg_index)
            REG_LEFT_POINT:    left_point_r    = value;
            REG_RISING_SLOPE:  rising_slope_r  = value;
            REG_FALLING_SLOPE: falling_slope_r = value;
            REG_RIGHT_POINT:   right_point_r   = value;
            REG_PEAK_HEIGHT:   peak_height_r   = value;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input spm_q8_8_t left, input spm_q8_8_t rise,
                                  input spm_q8_8_t fall, input spm_q8_8_t right,
                                  input spm_q1_15_t height);
        cfg_write(REG_LEFT_POINT, left);
        cfg_write(REG_RISING_SLOPE, rise);
        cfg_write(REG_FALLING_SLOPE, fall);
        cfg_write(REG_RIGHT_POINT, right);
        cfg_write(REG_PEAK_HEIGHT, height);
        cfg_bus.valid <= 1'b0;
    endtask

    // Receiver: checks each degree transaction and drives ready with random idling.
    initial
    begin
        degree_item_t want;
        degree_bus.ready = 1'b0;
        hold_seen        = 1'b0;
        hold_left        = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && degree_bus.valid && degree_bus.ready)
            begin
                if (pending_degrees.size() == 0)
                begin
                    $display("%0t: unexpected degree transaction, expected none, actual %0d",
                             $time, degree_bus.degree);
                    error_count++;
                end
                else
                begin
                    want = pending_degrees.pop_front();
                    if (degree_bus.degree !== want.degree)
                    begin
                        $display("%0t: degree mismatch, expected %0d, actual %0d",
                                 $time, want.degree, degree_bus.degree);
                        error_count++;
                    end
                    if (degree_bus.degree_undefined !== want.undefined)
                    begin
                        $display("%0t: undefined flag mismatch, expected %0b, actual %0b",
                                 $time, want.undefined, degree_bus.degree_undefined);
                        error_count++;
                    end
                end
            end
            if (hold_toggle != hold_seen)
            begin
                hold_seen = hold_toggle;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left != 0)
            begin
                degree_bus.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                degree_bus.ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    // Settings straight out of reset, with the sample extremes and undefined inputs.
    task automatic test_reset_defaults();
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh0000, 1'b0);
        send_sample(16'sh0001, 1'b0);
        send_sample(16'shFFFF, 1'b0);
        send_sample(16'sh0100, 1'b0);
        send_sample(16'shFF00, 1'b0);
        send_sample(16'sh0000, 1'b1);
        send_sample(16'sh8000, 1'b1);
        send_sample(16'sh7FFF, 1'b1);
        wait_for_degrees();
    endtask

    // Extreme register values: saturated arguments, flat sigmoids, zero and
    // above-one heights.
    task automatic test_register_extremes();
        apply_settings(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'd32768);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh0000, 1'b0);
        wait_for_degrees();
        apply_settings(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'hFFFF);
        send_sample(spm_q8_8_t'($urandom), 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        wait_for_degrees();
        apply_settings(16'sh0100, 16'sh0100, 16'shFF00, 16'sh0200, 16'd0);
        send_sample(16'sh0180, 1'b0);
        wait_for_degrees();
        apply_settings(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'd1);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        wait_for_degrees();
    endtask

    // Writes to indexes past the last register must leave the settings alone.
    // The mapped and unmapped writes run as one burst with valid held high.
    task automatic test_unmapped_index();
        cfg_write(REG_LEFT_POINT, 16'sh0100);
        cfg_write(REG_RISING_SLOPE, 16'sh0200);
        cfg_write(REG_FALLING_SLOPE, 16'shFE00);
        cfg_write(REG_RIGHT_POINT, 16'sh0300);
        cfg_write(REG_PEAK_HEIGHT, 16'd30000);
        for (int k = 0; k < (1 << CFG_INDEX_W) - FIRST_UNMAPPED_INDEX; k++)
        begin
            cfg_write(FIRST_UNMAPPED_INDEX + CFG_INDEX_W'(k), 16'($urandom));
        end
        cfg_bus.valid <= 1'b0;
        send_sample(16'sh0100, 1'b0);
        send_sample(16'sh0200, 1'b0);
        send_sample(16'sh0300, 1'b0);
        wait_for_degrees();
    endtask

    // Long receiver hold-off while the sender keeps offering, so the pipeline
    // fills and stalls its input.
    task automatic test_output_stall();
        apply_settings(pick_point(), pick_slope(), pick_slope(), pick_point(), pick_height());
        steady_flow = 1'b1;
        hold_toggle = ~hold_toggle;
        for (int k = 0; k < STALL_ITEMS; k++)
        begin
            send_sample(pick_sample(), ($urandom_range(9) == 0));
        end
        steady_flow = 1'b0;
        wait_for_degrees();
    endtask

    // Random settings per phase, random samples within each; one phase runs with
    // no idling on either side.
    task automatic test_random_settings();
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            apply_settings(pick_point(), pick_slope(), pick_slope(), pick_point(),
                           pick_height());
            steady_flow = (phase == STEADY_PHASE);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if ($urandom_range(9) == 0)
                begin
                    send_sample(spm_q8_8_t'($urandom), 1'b1);
                end
                else
                begin
                    send_sample(pick_sample(), 1'b0);
                end
            end
            steady_flow = 1'b0;
            wait_for_degrees();
        end
    endtask

    // Main sequence.
    initial
    begin
        rst_n                       = 1'b0;
        steady_flow                 = 1'b0;
        hold_toggle                 = 1'b0;
        error_count                 = 0;
        sample_bus.valid            = 1'b0;
        sample_bus.sample           = '0;
        sample_bus.sample_undefined = 1'b0;
        cfg_bus.valid               = 1'b0;
        cfg_bus.index               = '0;
        cfg_bus.data                = '0;
        left_point_r                = LEFT_POINT_RESET;
        rising_slope_r              = RISING_SLOPE_RESET;
        falling_slope_r             = FALLING_SLOPE_RESET;
        right_point_r               = RIGHT_POINT_RESET;
        peak_height_r               = PEAK_HEIGHT_RESET;
        for (int i = 0; i <= TABLE_ENTRIES; i++)
        begin
            logistic_lut[i] = logistic_entry(i);
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_unmapped_index();
        test_output_stall();
        test_random_settings();

        // Let any stray transaction show up before the verdict.
        wait_for_degrees();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/spm_pkg.sv
rtl/spm_sample_if.sv
rtl/spm_degree_if.sv
rtl/spm_cfg_if.sv
rtl/spm_sigmoid.sv
rtl/spm_combine.sv
rtl/sigmoid_product_membership.sv
rtl/spm_checker.sv
bench/testbench.sv
